[src/pid_motor_position_loop_top_defines.svh]
// ----------------------------------------------------------------------------
// pid_motor_position_loop_top_defines
// Assertion macros shared by the position loop RTL.
// ----------------------------------------------------------------------------
`ifndef PID_MOTOR_POSITION_LOOP_TOP_DEFINES_SVH
`define PID_MOTOR_POSITION_LOOP_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PIDMPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PIDMPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pidmpl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmpl_pkg
// Types and constants of the motor position PID loop.
// ----------------------------------------------------------------------------
package pidmpl_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEGRAL  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 8'd3;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_TARGET = 1'b1;

    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [7:0] SETTLE_LEVEL = 8'd100;
    localparam logic [4:0] SETTLE_TICKS = 5'd30;

    localparam logic signed [15:0] GAIN_PROP_RST      = 16'sd256;
    localparam logic signed [15:0] GAIN_INTEGRAL_RST  = 16'sd0;
    localparam logic signed [15:0] GAIN_DERIV_RST     = 16'sd0;
    localparam logic        [30:0] INTEGRAL_LIMIT_RST = 31'd1000;

    localparam int ACC_W = 51;

    typedef enum logic [1:0] {
        DRIVE_FWD  = 2'd0,
        DRIVE_BWD  = 2'd1,
        DRIVE_STOP = 2'd2
    } t_drive_mode;

    typedef struct packed {
        logic signed [15:0] prop;
        logic signed [15:0] integral;
        logic signed [15:0] deriv;
    } t_gains;

    typedef struct packed {
        logic               is_target;
        logic signed [31:0] err;
        logic signed [31:0] sum;
        logic signed [32:0] dif;
    } t_err_item;

    typedef struct packed {
        logic                    is_target;
        logic signed [ACC_W-1:0] acc;
    } t_acc_item;

endpackage

[src/pidmpl_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmpl_state
// Position, error, clamped error sum and error difference update; one beat per cycle while i_load is high.
// ----------------------------------------------------------------------------
module pidmpl_state (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic                    i_kind,
    input  logic signed [15:0]      i_delta,
    input  logic signed [31:0]      i_target,
    input  logic        [30:0]      i_limit,
    output pidmpl_pkg::t_err_item   o_item
);
    import pidmpl_pkg::*;

    logic signed [31:0] r_position;
    logic signed [31:0] r_target;
    logic signed [31:0] r_error_sum;
    logic signed [31:0] r_prev_err;
    t_err_item          r_item;

    logic signed [31:0] n_position;
    logic signed [32:0] n_diff;
    logic signed [31:0] n_err;
    logic signed [32:0] n_sum_raw;
    logic signed [32:0] n_lim;
    logic signed [32:0] n_lim_neg;
    logic signed [31:0] n_sum;
    logic signed [32:0] n_dif;

    always_comb begin
        n_position = r_position + 32'(i_delta);
        n_diff     = 33'(r_target) - 33'(n_position);
        if (n_diff[32] != n_diff[31]) begin
            n_err = n_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_err = n_diff[31:0];
        end
        n_sum_raw = 33'(r_error_sum) + 33'(n_err);
        n_lim     = signed'({2'b00, i_limit});
        n_lim_neg = -n_lim;
        if (n_sum_raw > n_lim) begin
            n_sum = n_lim[31:0];
        end else if (n_sum_raw < n_lim_neg) begin
            n_sum = n_lim_neg[31:0];
        end else begin
            n_sum = n_sum_raw[31:0];
        end
        n_dif = 33'(n_err) - 33'(r_prev_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_target    <= '0;
            r_error_sum <= '0;
            r_prev_err  <= '0;
        end else if (i_load) begin
            if (i_kind == KIND_TARGET) begin
                r_position  <= '0;
                r_target    <= i_target;
                r_error_sum <= '0;
                r_prev_err  <= '0;
            end else begin
                r_position  <= n_position;
                r_error_sum <= n_sum;
                r_prev_err  <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.is_target <= (i_kind == KIND_TARGET);
            r_item.err       <= n_err;
            r_item.sum       <= n_sum;
            r_item.dif       <= n_dif;
        end
    end

    assign o_item = r_item;

endmodule

[src/pidmpl_terms.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmpl_terms
// Gain products of the Q8.8 gains in one stage, their signed Q42.8 sum in the next.
// ----------------------------------------------------------------------------
module pidmpl_terms (
    input  logic                    i_clk,
    input  logic                    i_load_mul,
    input  logic                    i_load_acc,
    input  pidmpl_pkg::t_gains      i_gains,
    input  pidmpl_pkg::t_err_item   i_item,
    output pidmpl_pkg::t_acc_item   o_item
);
    import pidmpl_pkg::*;

    logic               r_mul_tgt;
    logic signed [47:0] r_p_prop;
    logic signed [47:0] r_p_int;
    logic signed [48:0] r_p_der;
    t_acc_item          r_item;

    logic signed [47:0] n_err_x;
    logic signed [47:0] n_sum_x;
    logic signed [48:0] n_dif_x;
    logic signed [47:0] n_kp_x;
    logic signed [47:0] n_ki_x;
    logic signed [48:0] n_kd_x;

    always_comb begin
        n_err_x = 48'(i_item.err);
        n_sum_x = 48'(i_item.sum);
        n_dif_x = 49'(i_item.dif);
        n_kp_x  = 48'(i_gains.prop);
        n_ki_x  = 48'(i_gains.integral);
        n_kd_x  = 49'(i_gains.deriv);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_mul) begin
            r_mul_tgt <= i_item.is_target;
            r_p_prop  <= n_err_x * n_kp_x;
            r_p_int   <= n_sum_x * n_ki_x;
            r_p_der   <= n_dif_x * n_kd_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_acc) begin
            r_item.is_target <= r_mul_tgt;
            r_item.acc       <= ACC_W'(r_p_prop) + ACC_W'(r_p_int) + ACC_W'(r_p_der);
        end
    end

    assign o_item = r_item;

endmodule

[src/pidmpl_drive.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmpl_drive
// Magnitude, saturation, direction and settle detection into the result register.
// ----------------------------------------------------------------------------
module pidmpl_drive (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  pidmpl_pkg::t_acc_item   i_item,
    output logic [7:0]              o_level,
    output pidmpl_pkg::t_drive_mode o_mode,
    output logic [4:0]              o_settle
);
    import pidmpl_pkg::*;

    logic [7:0]  r_level;
    t_drive_mode r_mode;
    logic [4:0]  r_settle;

    logic [ACC_W-1:0] n_mag;
    logic [7:0]       n_level;
    t_drive_mode      n_mode;
    logic [4:0]       n_settle;

    always_comb begin
        n_mag    = i_item.acc[ACC_W-1] ? ACC_W'(-i_item.acc) : ACC_W'(i_item.acc);
        n_level  = (|n_mag[ACC_W-1:16]) ? LEVEL_MAX : n_mag[15:8];
        n_mode   = i_item.acc[ACC_W-1] ? DRIVE_BWD : DRIVE_FWD;
        n_settle = r_settle;
        if (i_item.is_target) begin
            n_settle = '0;
        end else if (n_level > SETTLE_LEVEL) begin
            n_settle = '0;
        end else if (r_settle > SETTLE_TICKS) begin
            n_mode = DRIVE_STOP;
        end else begin
            n_settle = r_settle + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= '0;
        end else if (i_load) begin
            r_settle <= n_settle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !i_item.is_target) begin
            r_level <= n_level;
            r_mode  <= n_mode;
        end
    end

    assign o_level  = r_level;
    assign o_mode   = r_mode;
    assign o_settle = r_settle;

endmodule

[src/pid_motor_position_loop_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_position_loop_top
// Position PID loop for one motor with clamped integral and stop detection.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle while the output is not stalled. A tick beat
// gives one result beat through the input, state, product, sum and drive
// registers; a target beat gives none and clears the loop state in order with
// the beats around it. The rate is set by the position and error sum update in
// the state stage; the gain products and their sum each have a register stage
// of their own, and ready propagates back through the stage valid bits so an
// empty stage keeps taking beats while a result waits at the output.
module pid_motor_position_loop_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [47:0]                          i_s_axis_tdata,  // encoder_delta, target_position
    input  logic                                 i_s_axis_tuser,  // kind
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [15:0]                          o_m_axis_tdata,  // drive_level, drive_mode
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pidmpl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pidmpl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pidmpl_pkg::*;
    `include "pid_motor_position_loop_top_defines.svh"

    t_gains      r_gains;
    logic [30:0] r_limit;

    logic               r_a_valid;
    logic               r_a_kind;
    logic signed [15:0] r_a_delta;
    logic signed [31:0] r_a_target;
    logic               r_b_valid;
    logic               r_c_valid;
    logic               r_d_valid;
    logic               r_e_valid;

    logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;
    logic in_beat;

    t_err_item   b_item;
    t_acc_item   d_item;
    logic [7:0]  e_level;
    t_drive_mode e_mode;
    logic [4:0]  e_settle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop     <= GAIN_PROP_RST;
            r_gains.integral <= GAIN_INTEGRAL_RST;
            r_gains.deriv    <= GAIN_DERIV_RST;
            r_limit          <= INTEGRAL_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:      r_gains.prop     <= signed'(i_cfg_data[15:0]);
                CFG_GAIN_INTEGRAL:  r_gains.integral <= signed'(i_cfg_data[15:0]);
                CFG_GAIN_DERIV:     r_gains.deriv    <= signed'(i_cfg_data[15:0]);
                CFG_INTEGRAL_LIMIT: r_limit          <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        e_rdy = !r_e_valid || i_m_axis_tready;
        d_rdy = !r_d_valid || e_rdy;
        c_rdy = !r_c_valid || d_rdy;
        b_rdy = !r_b_valid || c_rdy;
        a_rdy = !r_a_valid || b_rdy;
    end

    assign o_s_axis_tready = a_rdy;
    assign in_beat         = i_s_axis_tvalid && a_rdy;

    // advance valid bits stage by stage; a target drops out at the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (a_rdy) r_a_valid <= i_s_axis_tvalid;
            if (b_rdy) r_b_valid <= r_a_valid;
            if (c_rdy) r_c_valid <= r_b_valid;
            if (d_rdy) r_d_valid <= r_c_valid;
            if (e_rdy) r_e_valid <= r_d_valid && !d_item.is_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_a_kind   <= i_s_axis_tuser;
            r_a_delta  <= signed'(i_s_axis_tdata[15:0]);
            r_a_target <= signed'(i_s_axis_tdata[47:16]);
        end
    end

    pidmpl_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_a_valid && b_rdy),
        .i_kind   (r_a_kind),
        .i_delta  (r_a_delta),
        .i_target (r_a_target),
        .i_limit  (r_limit),
        .o_item   (b_item)
    );

    pidmpl_terms u_terms (
        .i_clk      (i_clk),
        .i_load_mul (r_b_valid && c_rdy),
        .i_load_acc (r_c_valid && d_rdy),
        .i_gains    (r_gains),
        .i_item     (b_item),
        .o_item     (d_item)
    );

    pidmpl_drive u_drive (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_d_valid && e_rdy),
        .i_item   (d_item),
        .o_level  (e_level),
        .o_mode   (e_mode),
        .o_settle (e_settle)
    );

    assign o_m_axis_tvalid = r_e_valid;
    assign o_m_axis_tdata  = {6'd0, e_mode, e_level};

    `PIDMPL_ASSERT_NOW(a_stop_low_level, i_clk, i_rst_n,
        o_m_axis_tvalid && (e_mode == DRIVE_STOP), e_level <= SETTLE_LEVEL,
        "stop reported with drive level above settle threshold")

    `PIDMPL_ASSERT_NOW(a_stop_count_full, i_clk, i_rst_n,
        o_m_axis_tvalid && (e_mode == DRIVE_STOP), e_settle > SETTLE_TICKS,
        "stop reported before settle count saturated")

    `PIDMPL_ASSERT_NOW(a_empty_takes_beat, i_clk, i_rst_n,
        !r_a_valid, o_s_axis_tready,
        "input stage empty but not ready")

    `PIDMPL_ASSERT_NEXT(a_target_clears_settle, i_clk, i_rst_n,
        r_d_valid && d_item.is_target && e_rdy, e_settle == 5'd0,
        "target beat did not clear settle count")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor position PID loop.
// ----------------------------------------------------------------------------
// A table of directed beats covers reset, field extremes, error saturation,
// the stop rule, long runs of full-scale encoder deltas, ignored register
// indexes and the integral clamp. Random target/tick episodes follow under
// several gain settings and idling patterns. Every drive beat is checked
// against its table row where that gives a value, else an in-bench loop model.
module testbench;
    import pidmpl_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_PAUSE   = 8;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int REPORT_MAX    = 10;
    localparam longint ERR_MAX   = 64'sd2147483647;
    localparam longint ERR_MIN   = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

    typedef struct packed {
        logic [7:0]  level;
        t_drive_mode mode;
    } t_drive;

    typedef enum {OP_TICK, OP_TARGET, OP_CFG} t_plan_op;

    typedef struct {
        t_plan_op    op;
        logic [31:0] a;
        logic [31:0] b;
        int          reps;
        bit          typed;
        logic [7:0]  level;
        t_drive_mode mode;
    } t_plan_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pid_motor_position_loop_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // loop model state
    logic signed [15:0] k_prop, k_int, k_der;
    logic        [30:0] sum_limit;
    logic        [31:0] cur_pos;
    logic signed [31:0] cur_target, err_acc, last_err;
    logic        [5:0]  settle;

    t_drive pending_drive[$];

    int fail_count = 0;
    int beats_in = 0;
    int targets_in = 0;
    int results_seen = 0;
    int stops_seen = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int send_pct_of [4] = '{0, 79, 0, 13};
    int recv_pct_of [4] = '{0, 0, 79, 13};

    t_plan_row plan [34] = '{
        '{OP_TICK,   32'd0,          32'd0, 1,     1'b1, 8'd0,   DRIVE_FWD},
        '{OP_TARGET, 32'd200,        32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd0,          32'd0, 1,     1'b1, 8'd200, DRIVE_FWD},
        '{OP_TICK,   32'd32767,      32'd0, 1,     1'b1, 8'd255, DRIVE_BWD},
        '{OP_TICK,   32'hFFFF_8000,  32'd0, 1,     1'b1, 8'd201, DRIVE_FWD},
        '{OP_TARGET, 32'h8000_0000,  32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd1,          32'd0, 1,     1'b1, 8'd255, DRIVE_BWD},
        '{OP_TARGET, 32'h7FFF_FFFF,  32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'hFFFF_FFFF,  32'd0, 1,     1'b1, 8'd255, DRIVE_FWD},
        '{OP_TARGET, 32'd0,          32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd0,          32'd0, 31,    1'b1, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd0,          32'd0, 2,     1'b1, 8'd0,   DRIVE_STOP},
        '{OP_TICK,   -32'sd101,      32'd0, 1,     1'b1, 8'd101, DRIVE_FWD},
        '{OP_TICK,   32'd1,          32'd0, 1,     1'b1, 8'd100, DRIVE_FWD},
        '{OP_TARGET, 32'd0,          32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd50,         32'd0, 1,     1'b1, 8'd50,  DRIVE_BWD},
        '{OP_TICK,   32'd0,          32'd0, 30,    1'b1, 8'd50,  DRIVE_BWD},
        '{OP_TICK,   32'd0,          32'd0, 1,     1'b1, 8'd50,  DRIVE_STOP},
        '{OP_TARGET, 32'd0,          32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd32767,      32'd0, 40,    1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'hFFFF_8000,  32'd0, 3,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_CFG,    32'(CFG_IDX_UNUSED),     32'hFFFF_FFFF, 1, 1'b0, 8'd0, DRIVE_FWD},
        '{OP_TARGET, 32'd200,        32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd0,          32'd0, 1,     1'b1, 8'd200, DRIVE_FWD},
        '{OP_CFG,    32'(CFG_GAIN_PROP),      32'd0,         1, 1'b0, 8'd0, DRIVE_FWD},
        '{OP_CFG,    32'(CFG_GAIN_INTEGRAL),  32'd256,       1, 1'b0, 8'd0, DRIVE_FWD},
        '{OP_CFG,    32'(CFG_INTEGRAL_LIMIT), 32'd0,         1, 1'b0, 8'd0, DRIVE_FWD},
        '{OP_TARGET, 32'd500,        32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd0,          32'd0, 1,     1'b1, 8'd0,   DRIVE_FWD},
        '{OP_CFG,    32'(CFG_INTEGRAL_LIMIT), 32'h7FFF_FFFF, 1, 1'b0, 8'd0, DRIVE_FWD},
        '{OP_CFG,    32'(CFG_GAIN_DERIV),     32'h0000_8000, 1, 1'b0, 8'd0, DRIVE_FWD},
        '{OP_TARGET, 32'h7FFF_FFFF,  32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'hFFFF_FFFF,  32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD},
        '{OP_TICK,   32'd0,          32'd0, 1,     1'b0, 8'd0,   DRIVE_FWD}
    };

    function automatic void clear_loop();
        cur_pos  = '0;
        cur_target = '0;
        err_acc  = '0;
        last_err = '0;
        settle   = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_PROP:      k_prop = data[15:0];
            CFG_GAIN_INTEGRAL:  k_int = data[15:0];
            CFG_GAIN_DERIV:     k_der = data[15:0];
            CFG_INTEGRAL_LIMIT: sum_limit = data[30:0];
            default: ;
        endcase
    endfunction

    function automatic void loop_step(input logic kind, input logic [15:0] delta,
                                      input logic [31:0] tgt,
                                      output bit has_res, output t_drive res);
        longint err, sum, lim, acc, mag;
        has_res = 1'b0;
        res = '{8'd0, DRIVE_FWD};
        if (kind == KIND_TARGET) begin
            clear_loop();
            cur_target = tgt;
            return;
        end
        cur_pos = cur_pos + {{16{delta[15]}}, delta};
        err = longint'(cur_target) - longint'($signed(cur_pos));
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;
        lim = longint'(sum_limit);
        sum = longint'(err_acc) + err;
        if (sum > lim) sum = lim;
        else if (sum < -lim) sum = -lim;
        err_acc = 32'(sum);
        acc = err * longint'(k_prop) + sum * longint'(k_int)
            + (err - longint'(last_err)) * longint'(k_der);
        last_err = 32'(err);
        res.mode = (acc >= 0) ? DRIVE_FWD : DRIVE_BWD;
        mag = ((acc >= 0) ? acc : -acc) >> 8;
        res.level = (mag > longint'(LEVEL_MAX)) ? LEVEL_MAX : 8'(mag);
        if (res.level > SETTLE_LEVEL) begin
            settle = '0;
        end else if (settle > SETTLE_TICKS) begin
            res.mode = DRIVE_STOP;
        end else begin
            settle = settle + 6'd1;
        end
        has_res = 1'b1;
    endfunction

    task automatic note_fail(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic check_drive(input logic [15:0] beat);
        t_drive want;
        if (pending_drive.size() == 0) begin
            note_fail("unexpected drive beat", 0, beat);
            return;
        end
        want = pending_drive.pop_front();
        results_seen++;
        if (beat[7:0] != want.level) note_fail("drive_level", want.level, beat[7:0]);
        if (beat[9:8] != want.mode) note_fail("drive_mode", want.mode, beat[9:8]);
        if (beat[15:10] != '0) note_fail("tdata pad", 0, beat[15:10]);
        if (want.mode == DRIVE_STOP) stops_seen++;
    endtask

    // sink side: check, then pick next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_drive(o_m_axis_tdata);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_drive.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic kind, input logic [15:0] delta,
                             input logic [31:0] tgt, input bit typed, input t_drive typed_res);
        bit has_res;
        t_drive res;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {tgt, delta};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        loop_step(kind, delta, tgt, has_res, res);
        beats_in++;
        if (kind == KIND_TARGET) targets_in++;
        if (has_res) pending_drive.push_back(typed ? typed_res : res);
    endtask

    task automatic send_tick(input logic [15:0] delta);
        send_beat(KIND_TICK, delta, $urandom, 1'b0, '{8'd0, DRIVE_FWD});
    endtask

    task automatic send_target(input logic [31:0] tgt);
        send_beat(KIND_TARGET, 16'($urandom), tgt, 1'b0, '{8'd0, DRIVE_FWD});
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every drive result is back, then let the pipe empty
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic load_gains(input int p);
        logic [15:0] kp, ki, kd;
        logic [30:0] lim;
        case (p)
            0: begin kp = 16'd256; ki = 16'd0; kd = 16'd0; lim = 31'd1000; end
            1: begin
                kp = 16'($urandom_range(0, 512));
                ki = 16'($urandom_range(0, 32)) - 16'd16;
                kd = 16'($urandom_range(0, 1024)) - 16'd512;
                lim = 31'd5000;
            end
            2: begin kp = 16'h7FFF; ki = 16'h7FFF; kd = 16'h7FFF; lim = 31'h7FFF_FFFF; end
            3: begin kp = 16'h8000; ki = 16'h8000; kd = 16'h8000; lim = 31'd0; end
            5: begin kp = 16'd64; ki = 16'd1; kd = 16'd128; lim = 31'd50; end
            6: begin kp = 16'd0; ki = 16'd0; kd = 16'd0; lim = 31'($urandom); end
            default: begin
                kp = 16'($urandom);
                ki = 16'($urandom);
                kd = 16'($urandom);
                lim = 31'($urandom);
            end
        endcase
        cfg_write(CFG_GAIN_PROP, {16'($urandom), kp});
        cfg_write(CFG_GAIN_INTEGRAL, {16'($urandom), ki});
        cfg_write(CFG_GAIN_DERIV, {16'($urandom), kd});
        cfg_write(CFG_INTEGRAL_LIMIT, {1'($urandom), lim});
        cfg_write(8'($urandom_range(CFG_INTEGRAL_LIMIT + 1, 255)), $urandom);
    endtask

    function automatic logic [31:0] pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 32'($urandom_range(0, 200)) - 32'd100;
        if (r < 7) return 32'($urandom_range(0, 200000)) - 32'd100000;
        if (r < 9) return $urandom;
        case ($urandom_range(0, 2))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [15:0] pick_delta();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 16'd0;
        if (r < 16) return 16'($urandom_range(0, 8)) - 16'd4;
        if (r < 19) return 16'($urandom_range(0, 2000)) - 16'd1000;
        return 16'($urandom);
    endfunction

    initial begin
        int n, len;
        k_prop = GAIN_PROP_RST;
        k_int = GAIN_INTEGRAL_RST;
        k_der = GAIN_DERIV_RST;
        sum_limit = INTEGRAL_LIMIT_RST;
        clear_loop();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            case (plan[i].op)
                OP_CFG: begin
                    wait_drained();
                    cfg_write(plan[i].a[CFG_IDX_W-1:0], plan[i].b);
                end
                OP_TARGET: send_target(plan[i].a);
                default: begin
                    repeat (plan[i].reps)
                        send_beat(KIND_TICK, plan[i].a[15:0], $urandom, plan[i].typed,
                                  '{plan[i].level, plan[i].mode});
                end
            endcase
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_drained();
            load_gains(p);
            send_idle_pct = send_pct_of[p % 4];
            recv_stall_pct <= recv_pct_of[p % 4];
            if (p == 0) hold_token <= hold_token + 1;
            n = 0;
            while (n < PHASE_ITEMS) begin
                send_target(pick_target());
                n++;
                len = $urandom_range(5, 60);
                repeat (len) begin
                    // stray target breaks the episode now and then
                    if ($urandom_range(0, 99) < 5) send_target($urandom);
                    else send_tick(pick_delta());
                    n++;
                end
            end
        end

        wait_drained();
        $display("ran %0d input beats (%0d targets) under %0d register writes",
                 beats_in, targets_in, reg_writes);
        $display("checked %0d drive results, %0d in stop mode, %0d failures",
                 results_seen, stops_seen, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
